[design/rlcd_pkg.sv]
// ----------------------------------------------------------------------------
// rlcd_pkg
// Types, command codes, wait codes and sequence tables shared by the
// character-LCD expander write sequencer.
// ----------------------------------------------------------------------------
package rlcd_pkg;

	typedef enum logic [2:0] {
		CMD_INIT      = 3'd0,
		CMD_BACKLIGHT = 3'd1,
		CMD_CLEAR     = 3'd2,
		CMD_CURSOR    = 3'd3,
		CMD_DRAW      = 3'd4
	} cmd_t;

	localparam logic [2:0] WAIT_1US  = 3'd0;
	localparam logic [2:0] WAIT_50US = 3'd1;
	localparam logic [2:0] WAIT_1MS  = 3'd2;
	localparam logic [2:0] WAIT_2MS  = 3'd3;
	localparam logic [2:0] WAIT_5MS  = 3'd4;

	localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
	localparam logic [1:0] REG_COLUMNS        = 2'd1;
	localparam logic [1:0] REG_ROWS           = 2'd2;
	localparam logic [1:0] REG_BACKLIGHT_BIT  = 2'd3;

	localparam logic [7:0] EN_MASK   = 8'h04;
	localparam logic [7:0] DATA_MASK = 8'h02;
	localparam logic [7:0] SET_DDRAM = 8'h80;
	localparam logic [7:0] BYTE_NOP  = 8'h00;
	localparam logic [7:0] BYTE_CLR  = 8'h01;

	localparam logic [5:0] INIT_WRITES   = 6'd36;
	localparam logic [5:0] NIBBLE_WRITES = 6'd8;

	typedef struct packed {
		logic [2:0] command;
		logic [5:0] column;
		logic [1:0] row;
		logic [7:0] character;
		logic       light_on;
	} request_t;

	typedef struct packed {
		logic [6:0] bus_address;
		logic [7:0] expander_byte;
		logic [2:0] wait_code;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [6:0] device_address;
		logic [2:0] backlight_bit;
	} bus_cfg_t;

	// One unit of work for the back end: either the whole init sequence or
	// one or two controller bytes.
	typedef struct packed {
		logic       is_init;
		logic       two_bytes;
		logic       lit;
		logic [7:0] byte0;
		logic [2:0] wait0;
		logic [7:0] byte1;
		logic [2:0] wait1;
		logic       data1;
	} job_t;

	typedef struct packed {
		logic [7:0] byte_val;
		logic [2:0] wait_code;
	} init_entry_t;

	// Entries 0 to 3 are single nibbles, entries 4 to 10 are full bytes.
	function automatic init_entry_t init_entry(input logic [3:0] idx);
		init_entry_t e;
		unique case (idx)
			4'd0:    e = '{8'h30, WAIT_5MS};
			4'd1:    e = '{8'h30, WAIT_1MS};
			4'd2:    e = '{8'h30, WAIT_1MS};
			4'd3:    e = '{8'h20, WAIT_1MS};
			4'd4:    e = '{8'h28, WAIT_50US};
			4'd5:    e = '{8'h08, WAIT_50US};
			4'd6:    e = '{8'h01, WAIT_2MS};
			4'd7:    e = '{8'h06, WAIT_50US};
			4'd8:    e = '{8'h0C, WAIT_50US};
			4'd9:    e = '{8'h00, WAIT_50US};
			4'd10:   e = '{8'h01, WAIT_2MS};
			default: e = '{8'h00, WAIT_1US};
		endcase
		return e;
	endfunction

	function automatic logic [7:0] row_base(input logic [1:0] r);
		logic [7:0] b;
		unique case (r)
			2'd0: b = 8'h00;
			2'd1: b = 8'h40;
			2'd2: b = 8'h14;
			2'd3: b = 8'h54;
		endcase
		return b;
	endfunction

endpackage

[design/char_lcd_expander_write_sequencer.sv]
// ----------------------------------------------------------------------------
// char_lcd_expander_write_sequencer
// Character-LCD request sequencer for an HD44780 in 4-bit mode behind an
// I2C port expander.
// ----------------------------------------------------------------------------
// Requests enter on push/full and are accepted when push is high and full is
// low. Expander writes leave on empty/pop: the oldest write sits on res while
// empty is low and is taken when pop is high. The configuration port writes
// one register per cycle with cfg_write high; write it only while idle.
// A request is classified in its accept cycle and queued as a job in a
// two-entry queue; the back end turns the head job into one write per cycle
// while the output register is free or popped. The job is registered in the
// queue, and its first write is then registered in the output register, on
// res. Init gives 36 writes, set backlight, clear and set cursor 4, an
// on-screen draw 8; unknown commands and off-screen draws give none.
// The back end sets the rate; new requests are taken while earlier jobs run.
// When the receiver stops popping, the output register holds its write, the
// back end stops, the queue fills and full rises after two jobs wait.
// Reset restores the register defaults (address 39, 16 columns, 2 rows,
// backlight bit 3), turns the backlight state on and empties everything.
// ----------------------------------------------------------------------------
module char_lcd_expander_write_sequencer #(
	parameter int ROW_TABLE_SIZE = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data,
	input  logic               push,
	output logic               full,
	input  rlcd_pkg::request_t req,
	output logic               empty,
	input  logic               pop,
	output rlcd_pkg::result_t  res
);
	import rlcd_pkg::*;

	bus_cfg_t bus_cfg;
	logic     job_push;
	job_t     job_in;
	logic     job_full;
	logic     job_pop;
	job_t     job_head;
	logic     job_valid;

	rlcd_front #(
		.ROW_TABLE_SIZE(ROW_TABLE_SIZE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.push     (push),
		.full     (full),
		.req      (req),
		.bus_cfg  (bus_cfg),
		.job_push (job_push),
		.job      (job_in),
		.job_full (job_full)
	);

	rlcd_job_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_job  (job_in),
		.wr_full (job_full),
		.rd_en   (job_pop),
		.rd_job  (job_head),
		.rd_valid(job_valid)
	);

	rlcd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.bus_cfg  (bus_cfg),
		.job_valid(job_valid),
		.job      (job_head),
		.job_pop  (job_pop),
		.empty    (empty),
		.pop      (pop),
		.res      (res)
	);

endmodule

[design/rlcd_front.sv]
// ----------------------------------------------------------------------------
// rlcd_front
// Holds the configuration registers and the backlight state, accepts
// requests and turns each one into a job for the back end.
// ----------------------------------------------------------------------------
module rlcd_front #(
	parameter int ROW_TABLE_SIZE = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [6:0]        cfg_data,
	input  logic              push,
	output logic              full,
	input  rlcd_pkg::request_t req,
	output rlcd_pkg::bus_cfg_t bus_cfg,
	output logic              job_push,
	output rlcd_pkg::job_t    job,
	input  logic              job_full
);
	import rlcd_pkg::*;

	localparam logic [2:0] ROW_LAST = 3'(ROW_TABLE_SIZE - 1);

	logic [6:0] device_address_q;
	logic [5:0] columns_q;
	logic [2:0] rows_q;
	logic [2:0] backlight_bit_q;
	logic       lit_q;

	logic       accept;
	logic       needed;
	logic       lit_next;
	logic [2:0] row_c;
	logic [7:0] cursor_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= 7'd39;
			columns_q        <= 6'd16;
			rows_q           <= 3'd2;
			backlight_bit_q  <= 3'd3;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DEVICE_ADDRESS: device_address_q <= cfg_data;
				REG_COLUMNS:        columns_q        <= cfg_data[5:0];
				REG_ROWS:           rows_q           <= cfg_data[2:0];
				REG_BACKLIGHT_BIT:  backlight_bit_q  <= cfg_data[2:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q <= 1'b1;
		end else if (accept) begin
			lit_q <= lit_next;
		end
	end

	assign full    = job_full;
	assign accept  = push && !job_full;
	assign bus_cfg = '{device_address_q, backlight_bit_q};

	// Row clamp for the cursor address: to the last display row, then to the
	// last entry of the row table.
	always_comb begin
		logic [2:0] r;
		r = {1'b0, req.row};
		if (rows_q == 3'd0) begin
			r = 3'd0;
		end else if (r >= rows_q) begin
			r = rows_q - 3'd1;
		end
		if (r >= ROW_LAST) begin
			r = (r > ROW_LAST) ? ROW_LAST : r;
		end
		row_c       = r;
		cursor_byte = SET_DDRAM | (8'({2'b00, req.column}) + row_base(row_c[1:0]));
	end

	always_comb begin
		needed   = 1'b0;
		lit_next = lit_q;
		job      = '{1'b0, 1'b0, lit_q, cursor_byte, WAIT_1MS,
		             req.character, WAIT_50US, 1'b1};
		unique case (req.command)
			CMD_INIT: begin
				needed      = 1'b1;
				lit_next    = 1'b1;
				job.is_init = 1'b1;
			end
			CMD_BACKLIGHT: begin
				needed    = 1'b1;
				lit_next  = req.light_on;
				job.byte0 = BYTE_NOP;
				job.wait0 = WAIT_50US;
			end
			CMD_CLEAR: begin
				needed    = 1'b1;
				job.byte0 = BYTE_CLR;
				job.wait0 = WAIT_2MS;
			end
			CMD_CURSOR: begin
				needed = 1'b1;
			end
			CMD_DRAW: begin
				needed        = (req.column < columns_q) && ({1'b0, req.row} < rows_q);
				job.two_bytes = 1'b1;
			end
			default: begin
				needed = 1'b0;
			end
		endcase
		job.lit = lit_next;
	end

	assign job_push = accept && needed;

endmodule

[design/rlcd_job_fifo.sv]
// ----------------------------------------------------------------------------
// rlcd_job_fifo
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rlcd_job_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  rlcd_pkg::job_t wr_job,
	output logic           wr_full,
	input  logic           rd_en,
	output rlcd_pkg::job_t rd_job,
	output logic           rd_valid
);
	import rlcd_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign do_wr    = wr_en && !wr_full;
	assign do_rd    = rd_en && rd_valid;
	assign wr_full  = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= !wr_ptr_q;
			if (do_rd) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(do_wr) - 2'(do_rd);
		end
	end

endmodule

[design/rlcd_back.sv]
// ----------------------------------------------------------------------------
// rlcd_back
// Expands the queue's head job into expander writes, one per cycle while
// the output register is free or popped, into a single output register.
// ----------------------------------------------------------------------------
module rlcd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  rlcd_pkg::bus_cfg_t bus_cfg,
	input  logic               job_valid,
	input  rlcd_pkg::job_t     job,
	output logic               job_pop,
	output logic               empty,
	input  logic               pop,
	output rlcd_pkg::result_t  res
);
	import rlcd_pkg::*;

	logic [5:0] w_q;
	logic       out_valid_q;
	result_t    res_q;

	logic        slot_free;
	logic        fire;
	logic        is_last;
	logic [5:0]  total;
	logic [5:0]  w_rel;
	logic [3:0]  idx;
	init_entry_t ent;
	logic [7:0]  b;
	logic [2:0]  wt;
	logic        flag;
	logic        nib_only;
	logic [3:0]  nib;
	logic [7:0]  v;
	result_t     res_d;

	assign slot_free = !out_valid_q || pop;
	assign fire      = job_valid && slot_free;

	always_comb begin
		w_rel    = w_q - NIBBLE_WRITES;
		idx      = (w_q < NIBBLE_WRITES) ? {1'b0, w_q[3:1]} : 4'(4'd4 + 4'(w_rel[5:2]));
		ent      = init_entry(idx);
		nib_only = 1'b0;
		flag     = 1'b0;
		if (job.is_init) begin
			b        = ent.byte_val;
			wt       = ent.wait_code;
			nib_only = (w_q < NIBBLE_WRITES);
			total    = INIT_WRITES;
		end else if (w_q[2]) begin
			b     = job.byte1;
			wt    = job.wait1;
			flag  = job.data1;
			total = 6'd8;
		end else begin
			b     = job.byte0;
			wt    = job.wait0;
			total = job.two_bytes ? 6'd8 : 6'd4;
		end
		nib = (!nib_only && w_q[1]) ? b[3:0] : b[7:4];
		v   = {nib, 4'b0000} | (flag ? DATA_MASK : 8'h00)
		      | (job.lit ? (8'h01 << bus_cfg.backlight_bit) : 8'h00);
		is_last = (w_q == total - 6'd1);
		res_d.bus_address = bus_cfg.device_address;
		if (!w_q[0]) begin
			// Enable-high half of the nibble strobe.
			res_d.expander_byte = v | EN_MASK;
			res_d.wait_code     = WAIT_1US;
		end else begin
			res_d.expander_byte = v & ~EN_MASK;
			res_d.wait_code     = (nib_only || w_q[1]) ? wt : WAIT_50US;
		end
		res_d.last = is_last;
	end

	assign job_pop = fire && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q         <= 6'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				w_q <= is_last ? 6'd0 : w_q + 6'd1;
			end
			if (slot_free) begin
				out_valid_q <= job_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign empty = !out_valid_q;
	assign res   = res_q;

	a_w_range: assert property (@(posedge clk) disable iff (!arst_n)
		w_q < INIT_WRITES)
		else $error("write counter beyond the longest sequence");

	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		(w_q != 6'd0) |-> job_valid)
		else $error("job left the queue in the middle of its sequence");

	a_last_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && is_last) |=> (w_q == 6'd0))
		else $error("write counter not rewound after the final write");

	a_last_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && is_last) |=> (!empty && res.last))
		else $error("final write of a job not marked");

endmodule

[tb/sv/lcd_write_tracker_pkg.sv]
// ----------------------------------------------------------------------------
// lcd_write_tracker_pkg
// Predicts the expander writes of the character-LCD write sequencer and keeps
// the writes that are still owed, so each write beat off the block can be
// checked field by field against the oldest one.
// ----------------------------------------------------------------------------
package lcd_write_tracker_pkg;

	import rlcd_pkg::*;

	class lcd_write_tracker;

		// Controller command bytes used by the power-up sequence.
		localparam logic [7:0] WAKE_8BIT    = 8'h30;
		localparam logic [7:0] SET_4BIT     = 8'h20;
		localparam logic [7:0] FUNC_2LINE   = 8'h28;
		localparam logic [7:0] DISPLAY_OFF  = 8'h08;
		localparam logic [7:0] ENTRY_MODE   = 8'h06;
		localparam logic [7:0] DISPLAY_ON   = 8'h0C;
		localparam int unsigned ROW_SLOTS   = 4;
		localparam int unsigned SHOW_LIMIT  = 10;

		logic [7:0] row_offset [ROW_SLOTS] = '{8'h00, 8'h40, 8'h14, 8'h54};

		logic [6:0] dev_addr;
		logic [5:0] n_columns;
		logic [2:0] n_rows;
		logic [2:0] bl_bit;
		bit         lit;

		result_t     pending_writes[$];
		int unsigned fault_count;
		int unsigned writes_checked;
		int unsigned per_command[8];
		int unsigned ignored_requests;

		function new();
			dev_addr  = 7'd39;
			n_columns = 6'd16;
			n_rows    = 3'd2;
			bl_bit    = 3'd3;
			lit       = 1'b1;
		endfunction

		function void set_register(logic [1:0] idx, logic [6:0] value);
			case (idx)
				REG_DEVICE_ADDRESS: dev_addr  = value;
				REG_COLUMNS:        n_columns = value[5:0];
				REG_ROWS:           n_rows    = value[2:0];
				REG_BACKLIGHT_BIT:  bl_bit    = value[2:0];
			endcase
		endfunction

		function void add_write(logic [7:0] b, logic [2:0] wt);
			result_t w;
			w.bus_address   = dev_addr;
			w.expander_byte = b;
			w.wait_code     = wt;
			w.last          = 1'b0;
			pending_writes.push_back(w);
		endfunction

		// The backlight mask is ORed in blindly, so it may land on the enable
		// or data flag bit; the enable-low write still clears bit 2.
		function void add_nibble(logic [7:0] nib, bit data, logic [2:0] wt);
			logic [7:0] v;
			v = (nib & 8'hF0) | (data ? DATA_MASK : 8'h00);
			if (lit)
				v = v | (8'h01 << bl_bit);
			add_write(v | EN_MASK, WAIT_1US);
			add_write(v & ~EN_MASK, wt);
		endfunction

		function void add_byte(logic [7:0] b, bit data, logic [2:0] wt);
			add_nibble(b & 8'hF0, data, WAIT_50US);
			add_nibble({b[3:0], 4'h0}, data, wt);
		endfunction

		function void add_cursor(logic [5:0] col, logic [1:0] row);
			int unsigned r;
			logic [7:0]  addr;
			r = row;
			if (n_rows == 0)
				r = 0;
			else if (r >= n_rows)
				r = n_rows - 1;
			if (r >= ROW_SLOTS)
				r = ROW_SLOTS - 1;
			addr = SET_DDRAM | 8'({2'b00, col} + row_offset[r]);
			add_byte(addr, 1'b0, WAIT_1MS);
		endfunction

		// Returns the number of writes the request is expected to cause.
		function int unsigned note_request(request_t r);
			int unsigned before_count;
			before_count = pending_writes.size();
			per_command[r.command]++;
			case (r.command)
				CMD_INIT: begin
					lit = 1'b1;
					add_nibble(WAKE_8BIT, 1'b0, WAIT_5MS);
					add_nibble(WAKE_8BIT, 1'b0, WAIT_1MS);
					add_nibble(WAKE_8BIT, 1'b0, WAIT_1MS);
					add_nibble(SET_4BIT, 1'b0, WAIT_1MS);
					add_byte(FUNC_2LINE, 1'b0, WAIT_50US);
					add_byte(DISPLAY_OFF, 1'b0, WAIT_50US);
					add_byte(BYTE_CLR, 1'b0, WAIT_2MS);
					add_byte(ENTRY_MODE, 1'b0, WAIT_50US);
					add_byte(DISPLAY_ON, 1'b0, WAIT_50US);
					add_byte(BYTE_NOP, 1'b0, WAIT_50US);
					add_byte(BYTE_CLR, 1'b0, WAIT_2MS);
				end
				CMD_BACKLIGHT: begin
					lit = r.light_on;
					add_byte(BYTE_NOP, 1'b0, WAIT_50US);
				end
				CMD_CLEAR: begin
					add_byte(BYTE_CLR, 1'b0, WAIT_2MS);
				end
				CMD_CURSOR: begin
					add_cursor(r.column, r.row);
				end
				CMD_DRAW: begin
					if (r.column < n_columns && r.row < n_rows) begin
						add_cursor(r.column, r.row);
						add_byte(r.character, 1'b1, WAIT_50US);
					end
				end
				default: begin
				end
			endcase
			if (pending_writes.size() > before_count)
				pending_writes[pending_writes.size() - 1].last = 1'b1;
			else
				ignored_requests++;
			return pending_writes.size() - before_count;
		endfunction

		function void check_write(result_t got);
			result_t want;
			if (pending_writes.size() == 0) begin
				fault_count++;
				if (fault_count <= SHOW_LIMIT)
					$display("%0t ns: write with nothing expected: addr=%h byte=%h wait=%0d last=%b",
						$time, got.bus_address, got.expander_byte, got.wait_code, got.last);
				return;
			end
			want = pending_writes.pop_front();
			writes_checked++;
			if (got.bus_address !== want.bus_address || got.expander_byte !== want.expander_byte ||
				got.wait_code !== want.wait_code || got.last !== want.last) begin
				fault_count++;
				if (fault_count <= SHOW_LIMIT)
					$display("%0t ns: write %0d mismatch: expected addr=%h byte=%h wait=%0d last=%b, got addr=%h byte=%h wait=%0d last=%b",
						$time, writes_checked, want.bus_address, want.expander_byte,
						want.wait_code, want.last, got.bus_address, got.expander_byte,
						got.wait_code, got.last);
			end
		endfunction

	endclass

endpackage

[tb/sv/tb_char_lcd_expander_write_sequencer.sv]
// ----------------------------------------------------------------------------
// tb_char_lcd_expander_write_sequencer
// Drives LCD requests into the write sequencer under several register
// settings, with random gaps on the request side and random stalls on the
// write side, and checks every expander write against a predicted sequence.
// ----------------------------------------------------------------------------
module tb_char_lcd_expander_write_sequencer;

	timeunit 1ns;
	timeprecision 1ps;

	import rlcd_pkg::*;
	import lcd_write_tracker_pkg::*;

	localparam logic [2:0]  CMD_UNUSED_FIRST = 3'd5;
	localparam logic [2:0]  CMD_UNUSED_LAST  = 3'd7;
	localparam int unsigned MAX_IDLE         = 12;
	localparam int unsigned SETTLE_CYCLES    = 10;
	localparam int unsigned DRAIN_CYCLES     = 40;
	localparam int unsigned ITEMS_PER_PHASE  = 40;
	localparam int unsigned PHASES           = 6;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     cfg_write = 1'b0;
	logic [1:0] cfg_index = REG_DEVICE_ADDRESS;
	logic [6:0] cfg_data  = '0;
	logic     push      = 1'b0;
	logic     full;
	request_t req       = '0;
	logic     empty;
	logic     pop       = 1'b0;
	result_t  res;

	lcd_write_tracker tracker = new();
	bit          calm;
	int unsigned productive_count;
	int unsigned setting_count;

	char_lcd_expander_write_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.req       (req),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_500_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int unsigned pick_gap();
		return calm ? 0 : $urandom_range(0, MAX_IDLE);
	endfunction

	function automatic request_t make_request(logic [2:0] cmd, int unsigned col,
		int unsigned row, logic [7:0] chr, bit light);
		request_t r;
		r.command   = cmd;
		r.column    = 6'(col);
		r.row       = 2'(row);
		r.character = chr;
		r.light_on  = light;
		return r;
	endfunction

	// Mostly well-formed requests aimed at the visible screen, with some
	// off-screen positions and unused command codes mixed in.
	function automatic request_t random_request();
		int unsigned pick;
		int unsigned col;
		int unsigned row;
		logic [2:0]  cmd;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			cmd = CMD_INIT;
		else if (pick < 16)
			cmd = CMD_BACKLIGHT;
		else if (pick < 26)
			cmd = CMD_CLEAR;
		else if (pick < 46)
			cmd = CMD_CURSOR;
		else if (pick < 96)
			cmd = CMD_DRAW;
		else
			cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
		if ($urandom_range(0, 9) < 8)
			col = $urandom_range(0, tracker.n_columns - 1);
		else
			col = $urandom_range(0, 39);
		if ($urandom_range(0, 9) < 8)
			row = $urandom_range(0, tracker.n_rows - 1);
		else
			row = $urandom_range(0, 3);
		return make_request(cmd, col, row, 8'($urandom), 1'($urandom));
	endfunction

	// Called just after a rising edge. Handshake values are sampled at the
	// falling edge, where they are stable until the next rising edge.
	task automatic send_request(input request_t r);
		int unsigned gap;
		bit          taken;
		gap = pick_gap();
		repeat (gap) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		req  <= r;
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
		if (tracker.note_request(r) != 0)
			productive_count++;
	endtask

	task automatic wait_idle(input int unsigned settle);
		push <= 1'b0;
		@(posedge clk);
		while (tracker.pending_writes.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [6:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		tracker.set_register(idx, value);
	endtask

	task automatic apply_setting(input int unsigned addr, input int unsigned cols,
		input int unsigned nrows, input int unsigned bit_sel);
		write_register(REG_DEVICE_ADDRESS, 7'(addr));
		write_register(REG_COLUMNS, 7'(cols));
		write_register(REG_ROWS, 7'(nrows));
		write_register(REG_BACKLIGHT_BIT, 7'(bit_sel));
		cfg_write <= 1'b0;
		setting_count++;
	endtask

	// Write side: stall a random number of cycles, then take one beat.
	initial begin
		int unsigned stall;
		bit          got_beat;
		result_t     beat;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = pick_gap();
			repeat (stall) begin
				pop <= 1'b0;
				@(posedge clk);
			end
			pop <= 1'b1;
			do begin
				@(negedge clk);
				got_beat = !empty;
				beat     = res;
				@(posedge clk);
			end while (!got_beat);
			tracker.check_write(beat);
		end
	end

	initial begin
		int          ph;
		int          c;
		int unsigned phase_start;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings: 16 columns, 2 rows, bit 3.
		calm = 1'b0;
		send_request(make_request(CMD_INIT, 0, 0, 8'h00, 1'b0));
		send_request(make_request(CMD_BACKLIGHT, 0, 0, 8'h00, 1'b0));
		send_request(make_request(CMD_CLEAR, 39, 3, 8'hFF, 1'b1));
		send_request(make_request(CMD_DRAW, 0, 0, 8'h00, 1'b0));
		send_request(make_request(CMD_BACKLIGHT, 39, 3, 8'hFF, 1'b1));
		send_request(make_request(CMD_DRAW, 15, 1, 8'hFF, 1'b1));
		send_request(make_request(CMD_DRAW, 16, 0, 8'h41, 1'b0));
		send_request(make_request(CMD_DRAW, 0, 2, 8'h42, 1'b0));
		send_request(make_request(CMD_DRAW, 39, 3, 8'h43, 1'b1));
		send_request(make_request(CMD_CURSOR, 0, 0, 8'h00, 1'b0));
		send_request(make_request(CMD_CURSOR, 39, 1, 8'h00, 1'b0));
		send_request(make_request(CMD_CURSOR, 5, 2, 8'h00, 1'b0));
		send_request(make_request(CMD_CURSOR, 39, 3, 8'hFF, 1'b1));
		for (c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
			send_request(make_request(3'(c), 3, 1, 8'h55, 1'b0));
		send_request(make_request(CMD_BACKLIGHT, 0, 0, 8'h00, 1'b0));
		send_request(make_request(CMD_INIT, 21, 2, 8'hAA, 1'b0));
		send_request(make_request(CMD_DRAW, 7, 1, 8'hA5, 1'b0));
		send_request(make_request(CMD_DRAW, 32, 0, 8'h5A, 1'b1));
		send_request(make_request(CMD_DRAW, 10, 0, 8'h5A, 1'b1));

		for (ph = 0; ph < PHASES; ph++) begin
			wait_idle(SETTLE_CYCLES);
			case (ph)
				0: apply_setting(127, 40, 4, 7);
				1: apply_setting(0, 1, 1, 0);
				2: apply_setting(85, 20, 4, 2);
				3: apply_setting(42, 8, 3, 1);
				default: apply_setting($urandom_range(0, 127), $urandom_range(1, 40),
					$urandom_range(1, 4), $urandom_range(0, 7));
			endcase
			calm = (ph % 3 == 1);
			phase_start = productive_count;
			while (productive_count - phase_start < ITEMS_PER_PHASE) begin
				if ((ph == 0 && productive_count - phase_start == 20) ||
					$urandom_range(0, 79) == 0)
					wait_idle(0);
				send_request(random_request());
			end
		end

		wait_idle(0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d init, %0d backlight, %0d clear, %0d cursor, %0d draw requests,",
			tracker.per_command[CMD_INIT], tracker.per_command[CMD_BACKLIGHT],
			tracker.per_command[CMD_CLEAR], tracker.per_command[CMD_CURSOR],
			tracker.per_command[CMD_DRAW]);
		$display("%0d with no writes, %0d register settings, %0d write beats, %0d faults.",
			tracker.ignored_requests, setting_count + 1,
			tracker.writes_checked, tracker.fault_count);
		if (tracker.fault_count == 0 && tracker.pending_writes.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[files.f]
design/rlcd_pkg.sv
design/rlcd_front.sv
design/rlcd_job_fifo.sv
design/rlcd_back.sv
design/char_lcd_expander_write_sequencer.sv
tb/sv/lcd_write_tracker_pkg.sv
tb/sv/tb_char_lcd_expander_write_sequencer.sv
